/* sv/rte_pkg.sv */
// Shared types and constants for the rigid transform engine.
// No dependencies; imported by rte_dot3, rigid_transform_engine and the testbench.
package rte_pkg;

  localparam int WORD_W = 32;
  localparam int PROD_W = 2 * WORD_W;
  localparam int SUM_W  = PROD_W + 4;
  localparam int DIM    = 3;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_POINT  = 2'd1,
    OP_VECTOR = 2'd2,
    OP_INVERT = 2'd3
  } op_e;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [PROD_W-1:0] prod_t;

endpackage

/* sv/rte_dot3.sv */
// Sum of three products with optional negation, round half up, offset add and saturation.
// Depends on rte_pkg for the word and product widths.
module rte_dot3 #(
  parameter int FRAC_BITS   = 16,
  parameter int COORD_WIDTH = 32
) (
  input  rte_pkg::prod_t prod_i [rte_pkg::DIM],
  input  rte_pkg::word_t add_i,
  input  logic           neg_i,
  output rte_pkg::word_t value_o,
  output logic           clipped_o
);
  import rte_pkg::*;

  localparam int SAT_W = (COORD_WIDTH < WORD_W) ? COORD_WIDTH : WORD_W;
  localparam logic signed [SUM_W-1:0] SatTop = (SUM_W'(1) <<< (SAT_W - 1)) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] SatBot = -SatTop - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] Half   = SUM_W'(1) <<< (FRAC_BITS - 1);

  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] signed_sum;
  logic signed [SUM_W-1:0] scaled;
  logic signed [SUM_W-1:0] total;
  logic signed [SUM_W-1:0] clamped;

  always_comb begin
    sum        = SUM_W'(prod_i[0]) + SUM_W'(prod_i[1]) + SUM_W'(prod_i[2]);
    signed_sum = neg_i ? -sum : sum;
    scaled     = (signed_sum + Half) >>> FRAC_BITS;
    total      = scaled + SUM_W'(add_i);
    clipped_o  = 1'b0;
    clamped    = total;
    if (total > SatTop) begin
      clamped   = SatTop;
      clipped_o = 1'b1;
    end else if (total < SatBot) begin
      clamped   = SatBot;
      clipped_o = 1'b1;
    end
    value_o = clamped[WORD_W-1:0];
  end

endmodule

/* sv/rigid_transform_engine.sv */
// Top level of the rigid transform engine: matrix store, multiply stage, output register.
// Depends on rte_pkg and instantiates three rte_dot3 units.
//
//  channel | direction | handshake             | payload
//  in      | input     | in_valid_i/in_stall_o | op, row, col, coeff_value, point_x/y/z
//  out     | output    | out_valid_o/out_stall_i | out_x, out_y, out_z, saturated
//
// One word is taken per cycle while in_stall_o is low; a result passes the input, product and output registers.
// The nine 32x32 multipliers set the pace: products are registered before the sums.
// An invert word in the product stage holds the next word back while the new matrix is written.
// Reset clears the matrix to zero and empties every stage.
// A stalled result blocks only the stages behind it that are full.
module rigid_transform_engine #(
  parameter int FRAC_BITS   = 16,
  parameter int COORD_WIDTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          op_i,
  input  logic [1:0]          row_i,
  input  logic [1:0]          col_i,
  input  rte_pkg::word_t      coeff_value_i,
  input  rte_pkg::word_t      point_x_i,
  input  rte_pkg::word_t      point_y_i,
  input  rte_pkg::word_t      point_z_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rte_pkg::word_t      out_x_o,
  output rte_pkg::word_t      out_y_o,
  output rte_pkg::word_t      out_z_o,
  output logic                saturated_o
);
  import rte_pkg::*;

  word_t mat_q [DIM][DIM+1];

  logic  v1_q;
  op_e   op1_q;
  logic [1:0] row1_q;
  logic [1:0] col1_q;
  word_t coeff1_q;
  word_t pt1_q [DIM];

  logic  v2_q;
  op_e   op2_q;
  prod_t prod_d [DIM][DIM];
  prod_t prod_q [DIM][DIM];
  word_t add_d [DIM];
  word_t add_q [DIM];

  logic  v3_q;
  word_t res_q [DIM];
  logic  sat_q;

  word_t dot_val [DIM];
  logic  dot_clip [DIM];

  logic  accept;
  logic  s1_adv;
  logic  s2_adv;
  logic  s2_ready;
  logic  s3_ready;
  logic  s3_load;
  logic  inv2;
  logic  res2;

  assign inv2     = (op2_q == OP_INVERT);
  assign res2     = (op2_q == OP_POINT) || (op2_q == OP_VECTOR);
  assign s3_ready = !v3_q || !out_stall_i;
  assign s2_adv   = v2_q && (!res2 || s3_ready);
  assign s3_load  = v2_q && res2 && s3_ready;
  assign s2_ready = !v2_q || s2_adv;
  assign s1_adv   = v1_q && s2_ready && !(v2_q && inv2);
  assign in_stall_o = v1_q && !s1_adv;
  assign accept   = in_valid_i && !in_stall_o;

  always_comb begin
    for (int r = 0; r < DIM; r++) begin
      add_d[r] = (op1_q == OP_POINT) ? mat_q[r][DIM] : '0;
      for (int c = 0; c < DIM; c++) begin
        if (op1_q == OP_INVERT) begin
          prod_d[r][c] = PROD_W'(mat_q[c][r]) * PROD_W'(mat_q[c][DIM]);
        end else begin
          prod_d[r][c] = PROD_W'(mat_q[r][c]) * PROD_W'(pt1_q[c]);
        end
      end
    end
  end

  for (genvar g = 0; g < DIM; g++) begin : g_dot
    rte_dot3 #(
      .FRAC_BITS  (FRAC_BITS),
      .COORD_WIDTH(COORD_WIDTH)
    ) u_dot (
      .prod_i   (prod_q[g]),
      .add_i    (add_q[g]),
      .neg_i    (inv2),
      .value_o  (dot_val[g]),
      .clipped_o(dot_clip[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (accept) begin
        v1_q <= 1'b1;
      end else if (s1_adv) begin
        v1_q <= 1'b0;
      end
      if (s1_adv) begin
        v2_q <= 1'b1;
      end else if (s2_adv) begin
        v2_q <= 1'b0;
      end
      if (s3_load) begin
        v3_q <= 1'b1;
      end else if (!out_stall_i) begin
        v3_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < DIM; r++) begin
        for (int c = 0; c <= DIM; c++) begin
          mat_q[r][c] <= '0;
        end
      end
    end else if (s2_adv && inv2) begin
      for (int r = 0; r < DIM; r++) begin
        for (int c = 0; c < DIM; c++) begin
          mat_q[r][c] <= mat_q[c][r];
        end
        mat_q[r][DIM] <= dot_val[r];
      end
    end else if (s1_adv && (op1_q == OP_LOAD)) begin
      for (int r = 0; r < DIM; r++) begin
        for (int c = 0; c <= DIM; c++) begin
          if ((row1_q == 2'(r)) && (col1_q == 2'(c))) begin
            mat_q[r][c] <= coeff1_q;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op1_q    <= op_e'(op_i);
      row1_q   <= row_i;
      col1_q   <= col_i;
      coeff1_q <= coeff_value_i;
      pt1_q[0] <= point_x_i;
      pt1_q[1] <= point_y_i;
      pt1_q[2] <= point_z_i;
    end
    if (s1_adv) begin
      op2_q  <= op1_q;
      prod_q <= prod_d;
      add_q  <= add_d;
    end
    if (s3_load) begin
      res_q <= dot_val;
      sat_q <= dot_clip[0] | dot_clip[1] | dot_clip[2];
    end
  end

  assign out_valid_o = v3_q;
  assign out_x_o     = res_q[0];
  assign out_y_o     = res_q[1];
  assign out_z_o     = res_q[2];
  assign saturated_o = sat_q;

endmodule

/* tb/rigid_transform_engine_test.sv */
// Self-checking testbench for rigid_transform_engine: coefficient loads, point and vector
// transforms and rigid inversion, predicted bit for bit and checked against the block.
// Depends on rte_pkg and the rigid_transform_engine RTL with its rte_dot3 units; needs no other files.
module rigid_transform_engine_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rte_pkg::*;

  localparam int FRAC = 16;
  localparam int ITEMS = 1950;

  typedef logic signed [79:0] wide_t;
  localparam wide_t HALF_LSB = wide_t'(1) <<< (FRAC - 1);
  localparam wide_t SAT_TOP = 80'sd2147483647;
  localparam wide_t SAT_BOT = -80'sd2147483648;
  localparam word_t ONE = 32'sh0001_0000;
  localparam word_t MAXW = 32'sh7fff_ffff;
  localparam word_t MINW = 32'sh8000_0000;

  typedef struct {
    op_e op;
    logic [1:0] row;
    logic [1:0] col;
    word_t coeff;
    word_t px;
    word_t py;
    word_t pz;
    int phase;
    bit drain;
  } word_item_t;

  typedef struct {
    word_t x;
    word_t y;
    word_t z;
    logic sat;
  } coord_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] op_i = '0;
  logic [1:0] row_i = '0;
  logic [1:0] col_i = '0;
  word_t coeff_value_i = '0;
  word_t point_x_i = '0;
  word_t point_y_i = '0;
  word_t point_z_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  word_t out_x_o;
  word_t out_y_o;
  word_t out_z_o;
  logic saturated_o;

  rigid_transform_engine uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .op_i(op_i),
    .row_i(row_i),
    .col_i(col_i),
    .coeff_value_i(coeff_value_i),
    .point_x_i(point_x_i),
    .point_y_i(point_y_i),
    .point_z_i(point_z_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_x_o(out_x_o),
    .out_y_o(out_y_o),
    .out_z_o(out_z_o),
    .saturated_o(saturated_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  word_item_t pending_words[$];
  coord_t expected_coords[$];
  word_t matrix[12];
  word_item_t cur;
  int cur_phase = 0;
  int gen_count = 0;
  int gen_phase = 0;
  bit drain_next = 1'b0;
  int errors = 0;
  int n_load = 0;
  int n_point = 0;
  int n_vector = 0;
  int n_invert = 0;
  int n_checked = 0;
  int n_clipped = 0;

  // Exact sum of three products, optionally negated, plus an offset, rounded half up and saturated to 32 bits.
  function automatic void round_dot(input logic [2:0][31:0] a, input logic [2:0][31:0] b,
                                    input word_t offset, input bit negate,
                                    output word_t res, output bit clip);
    wide_t acc;
    wide_t ea;
    wide_t eb;
    acc = '0;
    for (int k = 0; k < 3; k++) begin
      ea = $signed(a[k]);
      eb = $signed(b[k]);
      acc = acc + ea * eb;
    end
    if (negate) acc = -acc;
    ea = offset;
    acc = (acc + (ea <<< FRAC) + HALF_LSB) >>> FRAC;
    clip = 1'b0;
    if (acc > SAT_TOP) begin
      acc = SAT_TOP;
      clip = 1'b1;
    end else if (acc < SAT_BOT) begin
      acc = SAT_BOT;
      clip = 1'b1;
    end
    res = acc[31:0];
  endfunction

  function automatic void apply_word(input word_item_t w);
    word_t nxt[12];
    word_t res[3];
    word_t offset;
    logic [2:0][31:0] va;
    logic [2:0][31:0] vb;
    bit clip;
    bit any_clip;
    coord_t c;
    case (w.op)
      OP_LOAD: begin
        n_load++;
        if (w.row != 2'd3) matrix[w.row * 4 + w.col] = w.coeff;
      end
      OP_INVERT: begin
        n_invert++;
        vb = {matrix[11], matrix[7], matrix[3]};
        for (int r = 0; r < 3; r++) begin
          va = {matrix[8 + r], matrix[4 + r], matrix[r]};
          for (int k = 0; k < 3; k++) nxt[r * 4 + k] = matrix[k * 4 + r];
          round_dot(va, vb, '0, 1'b1, nxt[r * 4 + 3], clip);
        end
        matrix = nxt;
      end
      default: begin
        if (w.op == OP_POINT) n_point++;
        else n_vector++;
        any_clip = 1'b0;
        vb = {w.pz, w.py, w.px};
        for (int r = 0; r < 3; r++) begin
          va = {matrix[r * 4 + 2], matrix[r * 4 + 1], matrix[r * 4]};
          offset = (w.op == OP_POINT) ? matrix[r * 4 + 3] : '0;
          round_dot(va, vb, offset, 1'b0, res[r], clip);
          any_clip |= clip;
        end
        c.x = res[0];
        c.y = res[1];
        c.z = res[2];
        c.sat = any_clip;
        expected_coords.push_back(c);
      end
    endcase
  endfunction

  function automatic word_t rand_word();
    case ($urandom_range(7))
      0: begin
        case ($urandom_range(4))
          0: return MAXW;
          1: return MINW;
          2: return '0;
          3: return 32'sh0000_0001;
          default: return 32'shffff_ffff;
        endcase
      end
      1, 2, 3: return word_t'($urandom_range(32'h0008_0000)) - 32'sh0004_0000;
      default: return word_t'($urandom);
    endcase
  endfunction

  function automatic void add_item(input op_e op, input logic [1:0] row, input logic [1:0] col,
                                   input word_t coeff, input word_t x, input word_t y,
                                   input word_t z);
    word_item_t w;
    int ph;
    ph = gen_count * 3 / ITEMS;
    if (ph > 2) ph = 2;
    w.op = op;
    w.row = row;
    w.col = col;
    w.coeff = coeff;
    w.px = x;
    w.py = y;
    w.pz = z;
    w.phase = ph;
    w.drain = drain_next || (ph != gen_phase);
    drain_next = 1'b0;
    gen_phase = ph;
    if (!(op == OP_LOAD && row == 2'd3)) gen_count++;
    pending_words.push_back(w);
  endfunction

  function automatic void add_load(input logic [1:0] row, input logic [1:0] col,
                                   input word_t v);
    add_item(OP_LOAD, row, col, v, rand_word(), rand_word(), rand_word());
  endfunction

  function automatic void add_xform(input op_e op, input word_t x, input word_t y,
                                    input word_t z);
    add_item(op, 2'($urandom), 2'($urandom), rand_word(), x, y, z);
  endfunction

  function automatic void add_invert();
    add_item(OP_INVERT, 2'($urandom), 2'($urandom), rand_word(), rand_word(), rand_word(),
             rand_word());
  endfunction

  function automatic int sender_idle_pct(input int ph);
    return (ph == 0) ? 25 : (ph == 1) ? 75 : 0;
  endfunction

  function automatic int receiver_idle_pct(input int ph);
    return (ph == 0) ? 75 : (ph == 1) ? 25 : 0;
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) apply_word(cur);
      if (!in_valid_i || !in_stall_o) begin
        if (pending_words.size() > 0
            && !(pending_words[0].drain && expected_coords.size() > 0)
            && $urandom_range(99) >= sender_idle_pct(pending_words[0].phase)) begin
          cur = pending_words.pop_front();
          cur_phase = cur.phase;
          in_valid_i <= 1'b1;
          op_i <= cur.op;
          row_i <= cur.row;
          col_i <= cur.col;
          coeff_value_i <= cur.coeff;
          point_x_i <= cur.px;
          point_y_i <= cur.py;
          point_z_i <= cur.pz;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= rst_ni && ($urandom_range(99) < receiver_idle_pct(cur_phase));
  end

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin
    coord_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_coords.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h %h %h %b", $realtime,
                 out_x_o, out_y_o, out_z_o, saturated_o);
      end else begin
        want = expected_coords.pop_front();
        n_checked++;
        if (want.sat) n_clipped++;
        check_field("out_x", want.x, out_x_o);
        check_field("out_y", want.y, out_y_o);
        check_field("out_z", want.z, out_z_o);
        check_field("saturated", {31'b0, want.sat}, {31'b0, saturated_o});
      end
    end
  end

  initial begin
    int n;
    for (int i = 0; i < 12; i++) matrix[i] = '0;

    add_xform(OP_POINT, MAXW, MINW, 32'sh0001_8000);
    add_load(2'd0, 2'd0, ONE);
    add_load(2'd1, 2'd1, ONE);
    add_load(2'd2, 2'd2, ONE);
    add_load(2'd0, 2'd3, MAXW);
    add_load(2'd1, 2'd3, MINW);
    add_load(2'd2, 2'd3, 32'sh0002_8000);
    add_xform(OP_POINT, ONE, -ONE, 32'sh0000_0001);
    add_xform(OP_VECTOR, MINW, MAXW, '0);
    add_load(2'd3, 2'd3, 32'shdead_beef);
    add_invert();
    add_xform(OP_POINT, '0, '0, '0);
    add_load(2'd0, 2'd1, MAXW);
    add_load(2'd0, 2'd2, MINW);
    add_load(2'd1, 2'd0, 32'sh0000_0001);
    add_xform(OP_VECTOR, MAXW, MAXW, MINW);
    add_xform(OP_POINT, 32'sh0000_8000, MINW, MAXW);
    add_invert();
    add_xform(OP_POINT, 32'sh0000_8000, 32'shffff_8000, '0);
    add_xform(OP_VECTOR, ONE, ONE, ONE);

    drain_next = 1'b1;
    while (gen_count < ITEMS) begin
      if ($urandom_range(9) < 7) begin
        n = $urandom_range(1, 12);
        repeat (n) add_load(2'($urandom_range(2)), 2'($urandom_range(3)), rand_word());
        if ($urandom_range(4) == 0) add_invert();
        n = $urandom_range(2, 10);
        repeat (n) add_xform(op_e'($urandom_range(1, 2)), rand_word(), rand_word(),
                             rand_word());
      end else begin
        n = $urandom_range(1, 6);
        repeat (n) add_item(op_e'($urandom_range(3)), 2'($urandom), 2'($urandom),
                            rand_word(), rand_word(), rand_word(), rand_word());
      end
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(posedge clk_i);
    while (pending_words.size() != 0 || in_valid_i || expected_coords.size() != 0);
    repeat (12) @(posedge clk_i);

    $display("Covered %0d loads, %0d inversions, %0d point and %0d vector transforms.",
             n_load, n_invert, n_point, n_vector);
    $display("Compared %0d results, %0d of them clipped; %0d mismatches.",
             n_checked, n_clipped, errors);
    if (errors == 0 && expected_coords.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/rte_pkg.sv
sv/rte_dot3.sv
sv/rigid_transform_engine.sv
tb/rigid_transform_engine_test.sv
